// ----- rtl/core/jrot_pkg.sv -----
// ----------------------------------------------------------------------------
// Jacobian rotation package
// Shared types and register map for the 3x3 Jacobian rotation block.
// ----------------------------------------------------------------------------
package jrot_pkg;

	localparam int BUS_WIDTH  = 64;
	localparam int ADDR_WIDTH = 5;

	typedef enum logic [1:0] {
		REG_ROW0 = 2'd0,
		REG_ROW1 = 2'd1,
		REG_ROW2 = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

endpackage

// ----- rtl/core/jrot_cfg.sv -----
// ----------------------------------------------------------------------------
// Rotation register file
// Holds the three rotation rows behind the configuration port.
// ----------------------------------------------------------------------------
module jrot_cfg #(
	parameter int COEF_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [jrot_pkg::ADDR_WIDTH-1:0]    paddr,
	input  logic [jrot_pkg::BUS_WIDTH-1:0]     pwdata,
	output logic [jrot_pkg::BUS_WIDTH-1:0]     prdata,
	output logic                               pready,
	output logic [3*COEF_WIDTH-1:0]            rows [3]
);

	localparam int RW = 3 * COEF_WIDTH;
	localparam logic [RW-1:0] ROW0_RST = RW'(1) << (COEF_WIDTH - 2);
	localparam logic [RW-1:0] ROW1_RST = RW'(1) << (2 * COEF_WIDTH - 2);
	localparam logic [RW-1:0] ROW2_RST = RW'(1) << (3 * COEF_WIDTH - 2);

	logic [RW-1:0] row0_q;
	logic [RW-1:0] row1_q;
	logic [RW-1:0] row2_q;
	logic          wr_en;
	logic [1:0]    reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= ROW0_RST;
			row1_q <= ROW1_RST;
			row2_q <= ROW2_RST;
		end else if (wr_en) begin
			case (reg_sel)
				jrot_pkg::REG_ROW0: begin
					row0_q <= pwdata[RW-1:0];
				end
				jrot_pkg::REG_ROW1: begin
					row1_q <= pwdata[RW-1:0];
				end
				jrot_pkg::REG_ROW2: begin
					row2_q <= pwdata[RW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			jrot_pkg::REG_ROW0: prdata = jrot_pkg::BUS_WIDTH'(row0_q);
			jrot_pkg::REG_ROW1: prdata = jrot_pkg::BUS_WIDTH'(row1_q);
			jrot_pkg::REG_ROW2: prdata = jrot_pkg::BUS_WIDTH'(row2_q);
			default:            prdata = '0;
		endcase
	end

	assign rows[0] = row0_q;
	assign rows[1] = row1_q;
	assign rows[2] = row2_q;

endmodule

// ----- rtl/core/jrot_dot.sv -----
// ----------------------------------------------------------------------------
// Rotation dot product
// Three-stage pipeline for one output entry: multiply, sum and round,
// then scale and saturate.
// ----------------------------------------------------------------------------
module jrot_dot #(
	parameter int DATA_WIDTH = 32,
	parameter int COEF_WIDTH = 16
) (
	input  logic                         clk,
	input  jrot_pkg::pipe_en_t           en,
	input  logic signed [COEF_WIDTH-1:0] coef [3],
	input  logic signed [DATA_WIDTH-1:0] data [3],
	output logic signed [DATA_WIDTH-1:0] res
);

	localparam int PW   = DATA_WIDTH + COEF_WIDTH;
	localparam int AW   = PW + 2;
	localparam int FRAC = COEF_WIDTH - 2;
	localparam int QW   = AW - FRAC;
	localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC - 1);
	localparam logic signed [QW-1:0] QMAX = QW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
	localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

	logic signed [PW-1:0]         prod_s1 [3];
	logic signed [AW-1:0]         acc_s2;
	logic signed [DATA_WIDTH-1:0] res_s3;
	logic signed [QW-1:0]         q;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[j] <= PW'(coef[j]) * PW'(data[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			acc_s2 <= AW'(prod_s1[0]) + AW'(prod_s1[1]) + AW'(prod_s1[2]) + HALF;
		end
	end

	assign q = QW'(acc_s2 >>> FRAC);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (q > QMAX) begin
				res_s3 <= QMAX[DATA_WIDTH-1:0];
			end else if (q < QMIN) begin
				res_s3 <= QMIN[DATA_WIDTH-1:0];
			end else begin
				res_s3 <= q[DATA_WIDTH-1:0];
			end
		end
	end

	assign res = res_s3;

endmodule

// ----- rtl/core/jacobian_rotate_3x3_top.sv -----
// ----------------------------------------------------------------------------
// Jacobian rotation, 3x3
// Multiplies each incoming Jacobian on the left by a configured rotation.
//
// An item is accepted at a rising edge with start high and busy low; busy is
// always low, so a new item may be issued in every cycle. The item carries
// nine signed Q16.16 entries and a batch-end flag.
// The rotated item appears on the out_* ports with done high for exactly one
// cycle, once it has passed the s1, s2 and s3 stage registers. Throughput
// is one item per cycle, set by the three-stage multiply, sum-and-round,
// saturate pipeline that every one of the nine output entries has on its own.
// The receiver cannot stall, so nothing is held back in the pipeline.
// The rotation rows are written through the register port at byte
// addresses 0, 8 and 16. The user must change them only while no item is
// in flight; the block itself does not enforce this.
// Reset clears the pipeline valid bits and sets the rotation to identity.
// ----------------------------------------------------------------------------
module jacobian_rotate_3x3_top #(
	parameter int DATA_WIDTH = 32,
	parameter int COEF_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [jrot_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [jrot_pkg::BUS_WIDTH-1:0]  pwdata,
	output logic [jrot_pkg::BUS_WIDTH-1:0]  prdata,
	output logic                            pready,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [DATA_WIDTH-1:0]    in_m00,
	input  logic signed [DATA_WIDTH-1:0]    in_m01,
	input  logic signed [DATA_WIDTH-1:0]    in_m02,
	input  logic signed [DATA_WIDTH-1:0]    in_m10,
	input  logic signed [DATA_WIDTH-1:0]    in_m11,
	input  logic signed [DATA_WIDTH-1:0]    in_m12,
	input  logic signed [DATA_WIDTH-1:0]    in_m20,
	input  logic signed [DATA_WIDTH-1:0]    in_m21,
	input  logic signed [DATA_WIDTH-1:0]    in_m22,
	input  logic                            in_batch_end,
	output logic                            done,
	output logic signed [DATA_WIDTH-1:0]    out_m00,
	output logic signed [DATA_WIDTH-1:0]    out_m01,
	output logic signed [DATA_WIDTH-1:0]    out_m02,
	output logic signed [DATA_WIDTH-1:0]    out_m10,
	output logic signed [DATA_WIDTH-1:0]    out_m11,
	output logic signed [DATA_WIDTH-1:0]    out_m12,
	output logic signed [DATA_WIDTH-1:0]    out_m20,
	output logic signed [DATA_WIDTH-1:0]    out_m21,
	output logic signed [DATA_WIDTH-1:0]    out_m22,
	output logic                            out_batch_end
);

	logic [3*COEF_WIDTH-1:0]      rows [3];
	logic signed [DATA_WIDTH-1:0] jac [9];
	logic signed [DATA_WIDTH-1:0] res [9];
	jrot_pkg::pipe_en_t           en;
	logic                         accept;
	logic                         vld_s1;
	logic                         vld_s2;
	logic                         vld_s3;
	logic                         be_s1;
	logic                         be_s2;
	logic                         be_s3;

	jrot_cfg #(
		.COEF_WIDTH (COEF_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rows    (rows)
	);

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign jac[0] = in_m00;
	assign jac[1] = in_m01;
	assign jac[2] = in_m02;
	assign jac[3] = in_m10;
	assign jac[4] = in_m11;
	assign jac[5] = in_m12;
	assign jac[6] = in_m20;
	assign jac[7] = in_m21;
	assign jac[8] = in_m22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			be_s1 <= in_batch_end;
		end
		if (vld_s1) begin
			be_s2 <= be_s1;
		end
		if (vld_s2) begin
			be_s3 <= be_s2;
		end
	end

	assign en.s1 = accept;
	assign en.s2 = vld_s1;
	assign en.s3 = vld_s2;

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			logic signed [COEF_WIDTH-1:0] coef [3];
			logic signed [DATA_WIDTH-1:0] col [3];

			for (genvar j = 0; j < 3; j++) begin : g_term
				assign coef[j] = rows[i][j*COEF_WIDTH +: COEF_WIDTH];
				assign col[j]  = jac[3*j + k];
			end

			jrot_dot #(
				.DATA_WIDTH (DATA_WIDTH),
				.COEF_WIDTH (COEF_WIDTH)
			) u_dot (
				.clk  (clk),
				.en   (en),
				.coef (coef),
				.data (col),
				.res  (res[3*i + k])
			);
		end
	end

	assign done          = vld_s3;
	assign out_batch_end = be_s3;
	assign out_m00       = res[0];
	assign out_m01       = res[1];
	assign out_m02       = res[2];
	assign out_m10       = res[3];
	assign out_m11       = res[4];
	assign out_m12       = res[5];
	assign out_m20       = res[6];
	assign out_m21       = res[7];
	assign out_m22       = res[8];

endmodule

// ----- rtl/core/jrot_checker.sv -----
// ----------------------------------------------------------------------------
// Jacobian rotation port checker
// Watches the top-level item ports for timing and flag consistency.
// ----------------------------------------------------------------------------
module jrot_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic in_batch_end,
	input logic done,
	input logic out_batch_end
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("Busy was raised although the pipeline never stalls.");

	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("An accepted item did not complete three cycles later.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("A result appeared without an accepted item.");

	a_flag_passes: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_batch_end == $past(in_batch_end, 3)))
		else $error("The batch-end flag does not match its item.");

endmodule

bind jacobian_rotate_3x3_top jrot_checker u_jrot_checker (.*);
